// ----- rtl/jsu_pkg.sv -----
// Shared types and constants for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

  // Decoder phase codes
  localparam logic [1:0] PH_PLAIN = 2'd0;
  localparam logic [1:0] PH_ESC   = 2'd1;
  localparam logic [1:0] PH_HEX   = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // Characters the decoder looks for
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] UTF_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF_CONT  = 8'h80;

  // One accepted input transaction
  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } item_t;

  // Results caused by one input byte: up to three bytes, end flag on the final one
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            end_flag;
  } res_t;

  // Hex digit decode: bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/jsu_in_stage.sv -----
// Input register stage for the JSON string unescaper.
`default_nettype none

module jsu_in_stage import jsu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  take,      // decoder consumes the held item this cycle
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/jsu_decode.sv -----
// Escape and \u decoder: phase state plus single-pass result generation.
`default_nettype none

module jsu_decode import jsu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step,   // item taken this cycle
  input  wire item_t item,
  output res_t       res
);

  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  dc_r, dc_nxt;
  logic [15:0] code_r, code_nxt;
  logic        stop_r, stop_nxt;

  logic [1:0]  ph;
  logic [1:0]  dc;
  logic [15:0] cv;
  logic        st;
  logic [7:0]  c;
  logic [4:0]  hx;
  logic [15:0] cv_new;
  logic        plain;
  logic        pos;

  always_comb begin
    c  = item.data;
    hx = hex_decode(c);
    // first byte of a string starts from the reset state
    ph = item.first ? PH_PLAIN : phase_r;
    dc = item.first ? 2'd0 : dc_r;
    cv = item.first ? 16'd0 : code_r;
    st = item.first ? 1'b0 : stop_r;

    phase_nxt = ph;
    dc_nxt    = dc;
    code_nxt  = cv;
    stop_nxt  = st;
    cv_new    = cv;
    res       = '0;
    plain     = 1'b0;
    pos       = 1'b0;

    unique case (ph)
      PH_PLAIN: begin
        plain = 1'b1;
      end
      PH_ESC: begin
        if (c == CH_U) begin
          phase_nxt = PH_HEX;
          dc_nxt    = 2'd0;
          code_nxt  = 16'd0;
          stop_nxt  = 1'b0;
        end else begin
          phase_nxt = PH_PLAIN;
          res.cnt   = 2'd1;
          case (c)
            CH_N:    res.bytes[0] = CH_LF;
            CH_R:    res.bytes[0] = CH_CR;
            CH_T:    res.bytes[0] = CH_TAB;
            default: res.bytes[0] = c;
          endcase
        end
      end
      PH_HEX: begin
        if (dc == 2'd0 && !hx[4]) begin
          // not a \u escape after all: emit 'u', then treat byte as text
          res.bytes[0] = CH_U;
          res.cnt      = 2'd1;
          plain        = 1'b1;
          pos          = 1'b1;
        end else begin
          if (!st && hx[4]) begin
            cv_new = {cv[11:0], hx[3:0]};
          end
          stop_nxt = st | !hx[4];
          code_nxt = cv_new;
          if (dc == 2'd3) begin
            phase_nxt = PH_PLAIN;
            dc_nxt    = 2'd0;
            if (cv_new[15:7] == 9'd0) begin
              res.cnt      = 2'd1;
              res.bytes[0] = cv_new[7:0];
            end else if (cv_new[15:11] == 5'd0) begin
              res.cnt      = 2'd2;
              res.bytes[0] = UTF_LEAD2 | {3'd0, cv_new[10:6]};
              res.bytes[1] = UTF_CONT | {2'd0, cv_new[5:0]};
            end else begin
              res.cnt      = 2'd3;
              res.bytes[0] = UTF_LEAD3 | {4'd0, cv_new[15:12]};
              res.bytes[1] = UTF_CONT | {2'd0, cv_new[11:6]};
              res.bytes[2] = UTF_CONT | {2'd0, cv_new[5:0]};
            end
          end else begin
            dc_nxt = dc + 2'd1;
          end
        end
      end
      default: begin
        // finished: ignore until next first byte
      end
    endcase

    if (plain) begin
      phase_nxt = PH_PLAIN;
      if (c == CH_BSLASH) begin
        phase_nxt = PH_ESC;
      end else if (c == CH_QUOTE) begin
        phase_nxt              = PH_DONE;
        res.end_flag           = 1'b1;
        res.bytes[{1'b0, pos}] = 8'd0;
        res.cnt                = {1'b0, pos} + 2'd1;
      end else begin
        res.bytes[{1'b0, pos}] = c;
        res.cnt                = {1'b0, pos} + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      dc_r    <= 2'd0;
      code_r  <= 16'd0;
      stop_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      dc_r    <= dc_nxt;
      code_r  <= code_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/jsu_out_stage.sv -----
// Result register and byte serializer for the JSON string unescaper.
`default_nettype none

module jsu_out_stage import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire res_t       res,
  output logic            free,       // result register can take a new bundle
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_data,
  output logic            out_end,
  output logic            out_last
);

  res_t       res_r;
  logic       v_r;
  logic [1:0] idx_r;
  logic       last_beat;

  assign last_beat = (idx_r == res_r.cnt - 2'd1);
  assign free      = !v_r || (out_ready && last_beat);
  assign out_valid = v_r;
  assign out_last  = last_beat;
  assign out_end   = res_r.end_flag && last_beat;

  always_comb begin
    case (idx_r)
      2'd0:    out_data = res_r.bytes[0];
      2'd1:    out_data = res_r.bytes[1];
      default: out_data = res_r.bytes[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      idx_r <= 2'd0;
    end else if (load) begin
      v_r   <= (res.cnt != 2'd0);
      idx_r <= 2'd0;
    end else if (v_r && out_ready) begin
      if (last_beat) begin
        v_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/json_string_unescape_utf8_core.sv -----
// Top level of the JSON string unescaper with UTF-8 output for \u escapes.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tdata[7:0] raw byte, tuser first-of-string
//  out_    | out | out_tvalid/out_tready| tdata[7:0] decoded byte, tuser end mark,
//          |     |                      | tlast final result of the input byte
//
// Flow: an input transaction passes an input register, then the decoder
// writes its 0..3 result bytes into the result register together. Items
// with at most one result flow at one per cycle while out_tready is high;
// an item with k results holds the result serializer until all k bytes
// are taken, which sets the sustained rate.
// Reset: synchronous active-low rst_n clears the stage valids and the phase
// state; no clearing pass. Stalls on out_tready back up through in_tready.
`default_nettype none

module json_string_unescape_utf8_core import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tuser,   // [0] first
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tuser,  // [0] end_mark
  output logic            out_tlast
);

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  res_free;
  logic  step;
  res_t  res;

  assign in_item.data  = in_tdata;
  assign in_item.first = in_tuser;

  // decoder advances only when the result register can take the bundle
  assign step = item_valid && res_free;

  jsu_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  jsu_decode u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .res   (res)
  );

  jsu_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res       (res),
    .free      (res_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_end   (out_tuser),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/jsu_checker.sv -----
// Port-level checker for the JSON string unescaper, with its bind.
`default_nettype none

module jsu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [7:0] in_tdata,
  input wire logic       in_tuser,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tuser,
  input wire logic       out_tlast
);

  // a waiting input transaction holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("input changed while waiting");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // the end result carries a zero byte and closes its input byte's results
  a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'd0 && out_tlast)
    else $error("malformed end result");

  // results of one input byte come back to back
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a multi-byte result");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ----- tb/jsu_decode_checker.sv -----
// Checker for the JSON string unescaper: predicts decoded bytes per input transaction and compares.
`timescale 1ns / 100ps

module jsu_decode_checker import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tuser,
  input  logic       out_tlast,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       end_mark;
    logic       last;
  } dec_res_t;

  localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

  dec_res_t    utf8_expected[$];
  dec_res_t    step_res[3];
  int          step_n;

  // decoder state mirror
  logic [1:0]  dec_phase;
  logic [1:0]  pos_cnt;
  logic [15:0] code_acc;
  logic        hex_stop;

  int          n_err = 0;

  assign fail_count = n_err;

  // -1 when not a hex digit
  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  task emit_res(input logic [7:0] b, input logic e);
    step_res[step_n].data     = b;
    step_res[step_n].end_mark = e;
    step_res[step_n].last     = 1'b0;
    step_n++;
  endtask

  task plain_char(input logic [7:0] c);
    if (c == CH_BSLASH) begin
      dec_phase = PH_ESC;
    end else if (c == CH_QUOTE) begin
      dec_phase = PH_DONE;
      emit_res(8'h00, 1'b1);
    end else begin
      emit_res(c, 1'b0);
    end
  endtask

  task emit_code_point(input logic [15:0] v);
    if (v < ONE_BYTE_LIMIT) begin
      emit_res(v[7:0], 1'b0);
    end else if (v < TWO_BYTE_LIMIT) begin
      emit_res(UTF_LEAD2 | {3'b000, v[10:6]}, 1'b0);
      emit_res(UTF_CONT | {2'b00, v[5:0]}, 1'b0);
    end else begin
      emit_res(UTF_LEAD3 | {4'b0000, v[15:12]}, 1'b0);
      emit_res(UTF_CONT | {2'b00, v[11:6]}, 1'b0);
      emit_res(UTF_CONT | {2'b00, v[5:0]}, 1'b0);
    end
  endtask

  task decode_byte(input logic [7:0] c, input logic first);
    int         d;
    logic [7:0] b;
    step_n = 0;
    if (first) begin
      dec_phase = PH_PLAIN;
      pos_cnt   = 2'd0;
      code_acc  = 16'h0000;
      hex_stop  = 1'b0;
    end
    case (dec_phase)
      PH_PLAIN: begin
        plain_char(c);
      end
      PH_ESC: begin
        if (c == CH_U) begin
          dec_phase = PH_HEX;
          pos_cnt   = 2'd0;
          code_acc  = 16'h0000;
          hex_stop  = 1'b0;
        end else begin
          b = c;
          if (c == CH_N) b = CH_LF;
          else if (c == CH_R) b = CH_CR;
          else if (c == CH_T) b = CH_TAB;
          dec_phase = PH_PLAIN;
          emit_res(b, 1'b0);
        end
      end
      PH_HEX: begin
        d = hex_val(c);
        if (pos_cnt == 2'd0 && d < 0) begin
          // bad first position: drop the escape, literal 'u', reprocess byte
          dec_phase = PH_PLAIN;
          emit_res(CH_U, 1'b0);
          plain_char(c);
        end else begin
          if (!hex_stop && d >= 0) code_acc = {code_acc[11:0], d[3:0]};
          else hex_stop = 1'b1;
          if (pos_cnt == 2'd3) begin
            dec_phase = PH_PLAIN;
            pos_cnt   = 2'd0;
            emit_code_point(code_acc);
          end else begin
            pos_cnt = pos_cnt + 2'd1;
          end
        end
      end
      default: begin
        // string finished: ignore until next first byte
      end
    endcase
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) utf8_expected.push_back(step_res[i]);
  endtask

  always @(posedge clk) begin : monitor
    dec_res_t want;
    if (!rst_n) begin
      utf8_expected.delete();
      dec_phase = PH_PLAIN;
      pos_cnt   = 2'd0;
      code_acc  = 16'h0000;
      hex_stop  = 1'b0;
    end else begin
      // results first: latency keeps this edge's input out of the output
      if (out_tvalid && out_tready) begin
        if (utf8_expected.size() == 0) begin
          $error("unexpected result transaction: out_byte %h end_mark %b last %b",
                 out_tdata, out_tuser, out_tlast);
          n_err++;
        end else begin
          want = utf8_expected.pop_front();
          if (out_tdata !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, out_tdata);
            n_err++;
          end
          if (out_tuser !== want.end_mark) begin
            $error("end_mark: expected %b, actual %b", want.end_mark, out_tuser);
            n_err++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_tlast);
            n_err++;
          end
        end
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tuser);
    end
    pending <= utf8_expected.size();
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top: drives JSON string bodies into the unescaper and gives the verdict.
`timescale 1ns / 100ps

module tb;
  import jsu_pkg::*;

  localparam int RANDOM_ITEMS = 300;
  // cycles with no transaction on either channel before the run is declared hung
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 10;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  int         fail_count;
  int         pending;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         n_items;
  int         stall_cycles;
  logic       first_flag;

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  json_string_unescape_utf8_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  jsu_decode_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: back-pressure drawn fresh every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: any accepted transaction on either side resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** json_string_unescape_utf8_core: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // hex digit with random letter case
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'("0") + nib;
    if ($urandom_range(1)) return 8'("A") + nib - 8'd10;
    return 8'("a") + nib - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (is_hex_char(c));
    return c;
  endfunction

  // code point spread over the one-, two- and three-byte UTF-8 ranges
  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hFFFF));
      3:       return 16'($urandom_range(16'hD800, 16'hDFFF));   // lone surrogate halves
      default: begin
        case ($urandom_range(0, 5))
          0:       return 16'h0000;
          1:       return 16'h007F;
          2:       return 16'h0080;
          3:       return 16'h07FF;
          4:       return 16'h0800;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // One input transaction. tvalid stays high into the next call when no gap is
  // drawn, so it is never lowered and raised within one time step.
  task automatic send_byte(input logic [7:0] b, input logic f, input bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= f;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (counted) n_items++;
  endtask

  // next byte of the current string; only its first byte carries the first flag
  task automatic put_char(input logic [7:0] b);
    send_byte(b, first_flag, 1'b1);
    first_flag = 1'b0;
  endtask

  task automatic send_u_escape(input logic [15:0] code);
    put_char(CH_BSLASH);
    put_char(CH_U);
    for (int i = 3; i >= 0; i--) put_char(hex_char(code[4*i +: 4]));
  endtask

  // One string body: a mix of plain bytes and escapes, mostly closed by a quote,
  // sometimes followed by junk that the block must ignore.
  task automatic send_string();
    int         ntok;
    int         stop_pos;
    logic [7:0] c;
    first_flag = 1'b1;
    ntok = $urandom_range(1, 8);
    repeat (ntok) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          do c = 8'($urandom_range(255)); while (c == CH_BSLASH || c == CH_QUOTE);
          put_char(c);
        end
        3: begin
          // short escape: mapped control chars or pass-through
          put_char(CH_BSLASH);
          case ($urandom_range(0, 4))
            0:       c = CH_N;
            1:       c = CH_R;
            2:       c = CH_T;
            default: do c = 8'($urandom_range(255)); while (c == CH_U);
          endcase
          put_char(c);
        end
        4, 5: begin
          send_u_escape(pick_code());
        end
        6: begin
          // hex run cut short; remaining positions are still swallowed
          put_char(CH_BSLASH);
          put_char(CH_U);
          stop_pos = $urandom_range(1, 3);
          for (int i = 0; i < 4; i++) begin
            if (i < stop_pos) put_char(hex_char(4'($urandom_range(15))));
            else if (i == stop_pos) put_char(non_hex_byte());
            else put_char(8'($urandom_range(255)));
          end
        end
        7: begin
          // \u without any hex digit
          put_char(CH_BSLASH);
          put_char(CH_U);
          put_char(non_hex_byte());
        end
        8: begin
          put_char(8'($urandom_range(255)));
        end
        default: begin
          // noise, now and then restarting a string mid-stream
          first_flag = ($urandom_range(0, 7) == 0);
          put_char(8'($urandom_range(255)));
        end
      endcase
    end
    if ($urandom_range(0, 9) != 0) begin
      put_char(CH_QUOTE);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    end
  endtask

  initial begin : stimulus
    int base;
    in_tvalid    <= 1'b0;
    in_tdata     <= 8'h00;
    in_tuser     <= 1'b0;
    out_tready   <= 1'b0;
    rst_n        <= 1'b0;
    stall_cycles <= 0;
    send_idle_pct = 35;
    recv_idle_pct = 65;
    n_items       = 0;
    first_flag    = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed string: byte extremes, the n, r and t escapes, escaped quote,
    // code zero, a surrogate half, a hex run stopped by a quote in the last
    // position, \u followed straight by the closing quote, then an ignored byte.
    put_char(8'hFF);
    put_char(CH_BSLASH); put_char(CH_N);
    put_char(CH_BSLASH); put_char(CH_R);
    put_char(CH_BSLASH); put_char(CH_T);
    put_char(CH_BSLASH); put_char(CH_QUOTE);
    send_u_escape(16'h0000);
    send_u_escape(16'hD83D);
    put_char(CH_BSLASH); put_char(CH_U);
    put_char("7"); put_char("f"); put_char("F"); put_char(CH_QUOTE);
    put_char(CH_BSLASH); put_char(CH_U); put_char(CH_QUOTE);
    send_byte(8'h00, 1'b0, 1'b0);

    // Random strings under three idling profiles, the last one with none
    base = n_items;
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (n_items < base + RANDOM_ITEMS * (p + 1) / 3) send_string();
    end

    // Drain: wait for every expected result, then a short hold-off for strays
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("** json_string_unescape_utf8_core: PASSED **");
    end else begin
      $display("** json_string_unescape_utf8_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/jsu_pkg.sv
rtl/jsu_in_stage.sv
rtl/jsu_decode.sv
rtl/jsu_out_stage.sv
rtl/json_string_unescape_utf8_core.sv
rtl/jsu_checker.sv
tb/jsu_decode_checker.sv
tb/tb.sv
